// ----- rtl/pts_pkg.sv -----
// Shared types and constants for the priority time-slice scheduler.
package pts_pkg;

  localparam int CNT_W        = 10;
  localparam int PRI_W        = 8;
  localparam int SLOT_FIELD_W = 3;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [PRI_W-1:0] pri_t;

  localparam cnt_t CNT_MAX = cnt_t'((1 << CNT_W) - 1);

  // Action codes carried by an input item.
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  typedef enum logic [1:0] {
    ALU_DEC,
    ALU_RELOAD,
    ALU_GT
  } alu_op_t;

  typedef struct packed {
    cnt_t value;
    logic gt;
    logic zero;
  } alu_res_t;

endpackage

// ----- rtl/priority_time_slice_scheduler_top.sv -----
// Top level of the priority time-slice scheduler: sequencer, slot table and shared unit.
//
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  in_action, in_slot_index, in_load_counter,
//                                        in_load_priority
// out_     output     out_valid/out_stall out_running_task, out_switched,
//                                        out_running_counter, out_reloaded, out_stuck
//
// A load item goes straight to the final read and output steps; a tick that keeps the
// running task first passes the decrement step. A tick that reschedules adds one slot
// scan (a tick from the idle task skips the decrement step); a reload adds a rewrite
// pass and a second scan. Item time is set by the single read port of the slot table,
// which the scan and the reload pass walk one slot per cycle.
// rst_n is synchronous and active low; it clears every counter, priority and the
// running slot at once, so no clearing pass is needed.
// The input is held off (in_stall high) while an item is being worked on. A
// finished result waits in the output register, and the next item may be accepted
// meanwhile; the sequencer only stalls at its last step if that register is full.
module priority_time_slice_scheduler_top #(
  parameter int NUM_TASKS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_action,
  input  logic [2:0]          in_slot_index,
  input  pts_pkg::cnt_t       in_load_counter,
  input  pts_pkg::pri_t       in_load_priority,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_running_task,
  output logic                out_switched,
  output pts_pkg::cnt_t       out_running_counter,
  output logic                out_reloaded,
  output logic                out_stuck
);
  import pts_pkg::*;

  localparam int SLOT_W = $clog2(NUM_TASKS);
  localparam int IDX_W  = SLOT_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_SCAN_INIT,
    S_SCAN,
    S_PICK,
    S_RELOAD,
    S_FIN_RD,
    S_FIN
  } state_t;

  state_t              state_r;
  logic [SLOT_W-1:0]   cur_r;
  logic [SLOT_W-1:0]   before_r;
  logic [IDX_W-1:0]    scan_idx_r;
  logic [SLOT_W-1:0]   cmp_idx_r;
  logic                data_vld_r;
  logic [SLOT_W-1:0]   best_r;
  cnt_t                best_cnt_r;
  logic                reloaded_r;
  logic                stuck_r;

  logic                out_valid_r;
  logic [2:0]          out_task_r;
  logic                out_switched_r;
  cnt_t                out_cnt_r;
  logic                out_reloaded_r;
  logic                out_stuck_r;

  // Slot table and shared-unit connections.
  logic                wr_en;
  logic [SLOT_W-1:0]   wr_addr;
  cnt_t                wr_cnt;
  pri_t                wr_pri;
  logic [SLOT_W-1:0]   rd_addr;
  cnt_t                rd_cnt;
  pri_t                rd_pri;
  alu_op_t             alu_op;
  cnt_t                alu_b;
  alu_res_t            alu_res;

  logic                in_fire;
  logic                load_ok;
  logic                scan_more;
  logic                out_free;
  logic [SLOT_W+SLOT_FIELD_W-1:0] in_idx_ext;
  logic [SLOT_W+SLOT_FIELD_W-1:0] cur_ext;

  assign in_fire    = in_valid && !in_stall;
  assign in_idx_ext = (SLOT_W + SLOT_FIELD_W)'(in_slot_index);
  assign cur_ext    = (SLOT_W + SLOT_FIELD_W)'(cur_r);
  // A load to the idle slot or past the last slot is dropped.
  assign load_ok    = (in_slot_index != '0) && (int'(in_slot_index) < NUM_TASKS);
  assign scan_more  = scan_idx_r < LAST_IDX;
  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = state_r != S_IDLE;

  pts_slot_mem #(
    .DEPTH  (NUM_TASKS),
    .ADDR_W (SLOT_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_cnt  (wr_cnt),
    .wr_pri  (wr_pri),
    .rd_addr (rd_addr),
    .rd_cnt  (rd_cnt),
    .rd_pri  (rd_pri)
  );

  pts_alu u_alu (
    .op  (alu_op),
    .a   (rd_cnt),
    .b   (alu_b),
    .pri (rd_pri),
    .res (alu_res)
  );

  // Table port and shared-unit steering for each sequencer step.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_r;
    wr_cnt  = alu_res.value;
    wr_pri  = rd_pri;
    rd_addr = cur_r;
    alu_op  = ALU_GT;
    alu_b   = best_cnt_r;
    unique case (state_r)
      S_IDLE: begin
        // Loads write straight from the input item.
        wr_en   = in_fire && (in_action == ACT_LOAD) && load_ok;
        wr_addr = in_idx_ext[SLOT_W-1:0];
        wr_cnt  = in_load_counter;
        wr_pri  = in_load_priority;
      end
      S_DEC: begin
        // The running task's counter is counted down once per tick.
        alu_op = ALU_DEC;
        wr_en  = 1'b1;
      end
      S_SCAN: begin
        rd_addr = scan_idx_r[SLOT_W-1:0];
      end
      S_RELOAD: begin
        // Read slot i while slot i-1 is rewritten as half its counter plus priority.
        rd_addr = scan_idx_r[SLOT_W-1:0];
        alu_op  = ALU_RELOAD;
        wr_en   = data_vld_r;
        wr_addr = cmp_idx_r;
      end
      S_SCAN_INIT, S_PICK, S_FIN_RD, S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      before_r    <= '0;
      scan_idx_r  <= '0;
      cmp_idx_r   <= '0;
      data_vld_r  <= 1'b0;
      best_r      <= '0;
      best_cnt_r  <= '0;
      reloaded_r  <= 1'b0;
      stuck_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // In the last step the output register is refilled below instead.
      if (out_valid_r && !out_stall && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            before_r   <= cur_r;
            reloaded_r <= 1'b0;
            stuck_r    <= 1'b0;
            if (in_action == ACT_LOAD) begin
              state_r <= S_FIN_RD;
            end else if (cur_r == '0) begin
              state_r <= S_SCAN_INIT;
            end else begin
              state_r <= S_DEC;
            end
          end
        end
        S_DEC: begin
          // The counter is read during the cycle this step follows.
          state_r <= alu_res.zero ? S_SCAN_INIT : S_FIN_RD;
        end
        S_SCAN_INIT: begin
          scan_idx_r <= IDX_W'(1);
          data_vld_r <= 1'b0;
          best_r     <= '0;
          best_cnt_r <= '0;
          state_r    <= S_SCAN;
        end
        S_SCAN: begin
          // Strictly greater keeps the lowest index on a tie.
          if (data_vld_r && alu_res.gt) begin
            best_r     <= cmp_idx_r;
            best_cnt_r <= rd_cnt;
          end
          data_vld_r <= scan_more;
          cmp_idx_r  <= scan_idx_r[SLOT_W-1:0];
          if (scan_more) begin
            scan_idx_r <= scan_idx_r + IDX_W'(1);
          end else if (!data_vld_r) begin
            state_r <= S_PICK;
          end
        end
        S_PICK: begin
          if (best_r != '0) begin
            cur_r   <= best_r;
            state_r <= S_FIN_RD;
          end else if (!reloaded_r) begin
            reloaded_r <= 1'b1;
            scan_idx_r <= IDX_W'(1);
            data_vld_r <= 1'b0;
            state_r    <= S_RELOAD;
          end else begin
            // Nothing runnable even after a reload: keep the current task.
            stuck_r <= 1'b1;
            state_r <= S_FIN_RD;
          end
        end
        S_RELOAD: begin
          data_vld_r <= scan_more;
          cmp_idx_r  <= scan_idx_r[SLOT_W-1:0];
          if (scan_more) begin
            scan_idx_r <= scan_idx_r + IDX_W'(1);
          end else if (!data_vld_r) begin
            state_r <= S_SCAN_INIT;
          end
        end
        S_FIN_RD: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_task_r     <= cur_ext[2:0];
            out_switched_r <= cur_r != before_r;
            out_cnt_r      <= (cur_r == '0) ? '0 : rd_cnt;
            out_reloaded_r <= reloaded_r;
            out_stuck_r    <= stuck_r;
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_running_task    = out_task_r;
  assign out_switched        = out_switched_r;
  assign out_running_counter = out_cnt_r;
  assign out_reloaded        = out_reloaded_r;
  assign out_stuck           = out_stuck_r;

  // A stuck result can only come after a reload attempt.
  a_stuck_after_reload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stuck_r |-> out_reloaded_r)
    else $error("stuck reported without a reload");

  // A stuck result keeps the running task.
  a_stuck_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stuck_r |-> !out_switched_r)
    else $error("stuck result switched tasks");

  // The idle task always reports a zero counter.
  a_idle_zero_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_task_r == '0) |-> (out_cnt_r == '0))
    else $error("idle task shows a nonzero counter");

  // A successful pick never lands on the idle slot.
  a_pick_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PICK) && (best_r != '0) |=> (cur_r != '0))
    else $error("pick selected the idle slot");

endmodule

// ----- rtl/pts_slot_mem.sv -----
// Slot table memory: counter and priority per slot, with reset-cleared valid bits.
module pts_slot_mem #(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  pts_pkg::cnt_t       wr_cnt,
  input  pts_pkg::pri_t       wr_pri,
  input  logic [ADDR_W-1:0]   rd_addr,
  output pts_pkg::cnt_t       rd_cnt,
  output pts_pkg::pri_t       rd_pri
);
  import pts_pkg::*;

  typedef struct packed {
    cnt_t cnt;
    pri_t pri;
  } slot_word_t;

  slot_word_t mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  slot_word_t rd_data_r;
  logic rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= '{cnt: wr_cnt, pri: wr_pri};
    end
    rd_data_r <= mem[rd_addr];
  end

  // An entry never written reads as zero, which matches the reset contents.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_cnt = rd_valid_r ? rd_data_r.cnt : '0;
  assign rd_pri = rd_valid_r ? rd_data_r.pri : '0;

endmodule

// ----- rtl/pts_alu.sv -----
// Shared counter unit: decrement, halve-and-add reload, and magnitude compare.
module pts_alu (
  input  pts_pkg::alu_op_t  op,
  input  pts_pkg::cnt_t     a,
  input  pts_pkg::cnt_t     b,
  input  pts_pkg::pri_t     pri,
  output pts_pkg::alu_res_t res
);
  import pts_pkg::*;

  logic [CNT_W:0] sum;
  cnt_t value;

  assign sum = (CNT_W + 1)'(a >> 1) + (CNT_W + 1)'(pri);

  always_comb begin
    unique case (op)
      ALU_DEC:    value = (a == '0) ? '0 : a - cnt_t'(1);
      ALU_RELOAD: value = (sum > (CNT_W + 1)'(CNT_MAX)) ? CNT_MAX : sum[CNT_W-1:0];
      ALU_GT:     value = a;
      default:    value = a;
    endcase
  end

  assign res.value = value;
  assign res.gt    = a > b;
  assign res.zero  = value == '0;

endmodule

// ----- sim/pts_sched_checker.sv -----
// Checker that predicts and compares every scheduler decision seen on the result channel.
`timescale 1ns / 1ps

module pts_sched_checker #(
  parameter int NUM_TASKS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                in_action,
  input  logic [2:0]          in_slot_index,
  input  pts_pkg::cnt_t       in_load_counter,
  input  pts_pkg::pri_t       in_load_priority,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [2:0]          out_running_task,
  input  logic                out_switched,
  input  pts_pkg::cnt_t       out_running_counter,
  input  logic                out_reloaded,
  input  logic                out_stuck,
  output int unsigned         fail_count,
  output int unsigned         pending_count,
  output int unsigned         checked_count,
  output int unsigned         switch_count,
  output int unsigned         reload_count,
  output int unsigned         stuck_count
);
  import pts_pkg::*;

  typedef struct packed {
    logic [2:0] slot;
    logic       switched;
    cnt_t       counter;
    logic       reloaded;
    logic       stuck;
  } decision_t;

  cnt_t        remaining [NUM_TASKS];
  pri_t        weight    [NUM_TASKS];
  int unsigned running_slot;
  decision_t   expected_decisions [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    checked_count = 0;
    switch_count  = 0;
    reload_count  = 0;
    stuck_count   = 0;
  end

  // Largest nonzero counter above the idle slot; the lowest index wins a tie.
  function automatic int unsigned longest_remaining();
    int unsigned best = 0;
    int unsigned best_cnt = 0;
    for (int i = 1; i < NUM_TASKS; i++) begin
      if (remaining[i] > best_cnt) begin
        best_cnt = remaining[i];
        best = i;
      end
    end
    return best;
  endfunction

  // With every counter drained, all slots are refilled from their priorities first.
  function automatic void pick_next(output logic reloaded, output logic stuck);
    int unsigned nxt;
    int unsigned refill;
    reloaded = 1'b0;
    stuck = 1'b0;
    nxt = longest_remaining();
    if (nxt == 0) begin
      reloaded = 1'b1;
      for (int i = 1; i < NUM_TASKS; i++) begin
        refill = (remaining[i] >> 1) + weight[i];
        remaining[i] = (refill > CNT_MAX) ? CNT_MAX : cnt_t'(refill);
      end
      nxt = longest_remaining();
      stuck = (nxt == 0);
    end
    if (nxt != 0) running_slot = nxt;
  endfunction

  function automatic decision_t predict_decision(logic action, logic [2:0] slot, cnt_t cnt,
                                                 pri_t pri);
    decision_t   d;
    int unsigned prior;
    logic        reloaded;
    logic        stuck;
    prior = running_slot;
    reloaded = 1'b0;
    stuck = 1'b0;
    if (action == ACT_LOAD) begin
      if (slot != 0 && slot < NUM_TASKS) begin
        remaining[slot] = cnt;
        weight[slot] = pri;
      end
    end else if (running_slot == 0) begin
      pick_next(reloaded, stuck);
    end else begin
      if (remaining[running_slot] > 0) remaining[running_slot]--;
      if (remaining[running_slot] == 0) pick_next(reloaded, stuck);
    end
    d.slot     = running_slot[2:0];
    d.switched = (running_slot != prior);
    d.counter  = (running_slot != 0) ? remaining[running_slot] : '0;
    d.reloaded = reloaded;
    d.stuck    = stuck;
    return d;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t ns: mismatch on %s, got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    decision_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        remaining[i] = '0;
        weight[i] = '0;
      end
      running_slot = 0;
      expected_decisions.delete();
    end else begin
      // A result always belongs to an item accepted at an earlier edge.
      if (out_valid && !out_stall) begin
        if (expected_decisions.size() == 0) begin
          report_mismatch("result with no item outstanding, running_task",
                          out_running_task, 0);
        end else begin
          want = expected_decisions.pop_front();
          if (out_running_task !== want.slot)
            report_mismatch("running_task", out_running_task, want.slot);
          if (out_switched !== want.switched)
            report_mismatch("switched", out_switched, want.switched);
          if (out_running_counter !== want.counter)
            report_mismatch("running_counter", out_running_counter, want.counter);
          if (out_reloaded !== want.reloaded)
            report_mismatch("reloaded", out_reloaded, want.reloaded);
          if (out_stuck !== want.stuck)
            report_mismatch("stuck", out_stuck, want.stuck);
          checked_count++;
          switch_count += want.switched;
          reload_count += want.reloaded;
          stuck_count  += want.stuck;
        end
      end
      if (in_valid && !in_stall)
        expected_decisions.push_back(predict_decision(in_action, in_slot_index,
                                                      in_load_counter, in_load_priority));
    end
    pending_count = expected_decisions.size();
  end

endmodule

// ----- sim/priority_time_slice_scheduler_top_test.sv -----
// Testbench top: drives load and tick items into the scheduler and gives the verdict.
`timescale 1ns / 1ps

module priority_time_slice_scheduler_top_test;
  import pts_pkg::*;

  localparam int NUM_TASKS  = 8;
  localparam int RANDOM_ITEMS = 600;
  // The receiver holds off this many cycles once, long enough to back the block up.
  localparam int HOLD_CYCLES = 150;
  // Settle time after the last result, longer than the longest item.
  localparam int DRAIN_CYCLES = 60;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_action = ACT_TICK;
  logic [2:0] in_slot_index = '0;
  cnt_t       in_load_counter = '0;
  pri_t       in_load_priority = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_running_task;
  logic       out_switched;
  cnt_t       out_running_counter;
  logic       out_reloaded;
  logic       out_stuck;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned checked_count;
  int unsigned switch_count;
  int unsigned reload_count;
  int unsigned stuck_count;

  // Shared between the sender and the receiver: quiet turns random idling off on
  // both sides for a stretch, and hold_wanted asks the receiver for its long hold-off.
  logic        quiet = 1'b0;
  logic        hold_wanted = 1'b0;
  int unsigned items_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  priority_time_slice_scheduler_top #(
    .NUM_TASKS(NUM_TASKS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_slot_index      (in_slot_index),
    .in_load_counter    (in_load_counter),
    .in_load_priority   (in_load_priority),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_running_task   (out_running_task),
    .out_switched       (out_switched),
    .out_running_counter(out_running_counter),
    .out_reloaded       (out_reloaded),
    .out_stuck          (out_stuck)
  );

  pts_sched_checker #(
    .NUM_TASKS(NUM_TASKS)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_slot_index      (in_slot_index),
    .in_load_counter    (in_load_counter),
    .in_load_priority   (in_load_priority),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_running_task   (out_running_task),
    .out_switched       (out_switched),
    .out_running_counter(out_running_counter),
    .out_reloaded       (out_reloaded),
    .out_stuck          (out_stuck),
    .fail_count         (fail_count),
    .pending_count      (pending_count),
    .checked_count      (checked_count),
    .switch_count       (switch_count),
    .reload_count       (reload_count),
    .stuck_count        (stuck_count)
  );

  // Offers one item. Inputs only change at the falling edge. Until the payload is up,
  // each falling edge assigns in_valid exactly once: low for an idle cycle, or high with
  // the payload, which is taken at the first rising edge where in_stall is low.
  task automatic offer_item(logic action, logic [2:0] slot, cnt_t cnt, pri_t pri);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_action        <= action;
    in_slot_index    <= slot;
    in_load_counter  <= cnt;
    in_load_priority <= pri;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Ticks ignore the payload, so it is filled with noise to exercise every bit.
  task automatic offer_tick();
    offer_item(ACT_TICK, 3'($urandom), cnt_t'($urandom), pri_t'($urandom));
  endtask

  // Drains every slot and clears every priority, so the next reschedule gets stuck.
  task automatic wipe_slots();
    for (int s = 1; s < NUM_TASKS; s++) offer_item(ACT_LOAD, 3'(s), '0, '0);
  endtask

  // The receiver, unless quiet, stalls at random with a chance of 8 in a hundred. Once the sender asks,
  // it holds off for HOLD_CYCLES in a row, counted here, while items keep coming:
  // the output register fills, the sequencer waits and the input stalls too.
  initial begin : receiver
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_wanted && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 8);
      end
    end
  end

  initial begin : stimulus
    int unsigned n;
    int unsigned roll;
    logic [2:0]  slot;
    cnt_t        cnt;
    pri_t        pri;

    // Synchronous reset, held low from the start and then released once at a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Right after reset every counter and priority is zero, so the
    // first tick reloads and still finds nothing runnable.
    offer_tick();
    // A load to the idle slot is dropped; the next tick is stuck again.
    offer_item(ACT_LOAD, 3'd0, CNT_MAX, 8'hFF);
    offer_tick();
    // Both slots start drained, so the tick reloads them from their priorities and
    // slot 7 wins with the top priority.
    offer_item(ACT_LOAD, 3'd7, '0, 8'hFF);
    offer_item(ACT_LOAD, 3'd1, '0, 8'd1);
    offer_tick();
    // A full counter waits in slot 3 while slot 7 is rewritten in place: a load to
    // the running slot changes its values but does not reschedule.
    offer_item(ACT_LOAD, 3'd3, CNT_MAX, '0);
    offer_item(ACT_LOAD, 3'd7, 10'd2, 8'hFF);
    offer_tick();
    offer_tick();
    // Slot 3 takes over; cut it short and set up a tie between slots 5 and 6.
    offer_item(ACT_LOAD, 3'd3, 10'd1, '0);
    offer_item(ACT_LOAD, 3'd5, 10'd4, '0);
    offer_item(ACT_LOAD, 3'd6, 10'd4, 8'h80);
    offer_tick();
    // Slot 5 won the tie. A zero counter loaded into the running slot is not
    // decremented; the tick reschedules straight away, to slot 6.
    offer_item(ACT_LOAD, 3'd5, '0, 8'h7F);
    offer_tick();
    // With every slot drained and every priority zero while slot 6 runs, the reload
    // leaves everything at zero and the block keeps slot 6 with a stuck flag.
    wipe_slots();
    offer_tick();

    // Random part. Counters and priorities are mostly small so that running tasks
    // drain, reloads and switches come often; full-range values and the extremes
    // come in now and then. A full wipe now and then drives the block into stuck.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n >= 150) hold_wanted = 1'b1;
      quiet = (n >= 300 && n < 420);
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        wipe_slots();
        n += NUM_TASKS - 1;
      end else if (roll < 58) begin
        offer_tick();
        n++;
      end else begin
        slot = 3'($urandom_range(0, 7));
        roll = $urandom_range(0, 99);
        if (roll < 70)      cnt = cnt_t'($urandom_range(0, 7));
        else if (roll < 95) cnt = cnt_t'($urandom);
        else                cnt = CNT_MAX;
        roll = $urandom_range(0, 99);
        if (roll < 70)      pri = pri_t'($urandom_range(0, 5));
        else if (roll < 92) pri = pri_t'($urandom);
        else                pri = 8'hFF;
        offer_item(ACT_LOAD, slot, cnt, pri);
        // Loads to the idle slot are dropped by the block and do not count here.
        if (slot != 0) n++;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    quiet = 1'b0;

    // Wait for every outstanding result, then give the block time to show any
    // stray result before deciding.
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d load and tick items; %0d results compared field by field.",
             items_sent, checked_count);
    $display("Seen %0d task switches, %0d reloads and %0d stuck decisions.",
             switch_count, reload_count, stuck_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every item at its longest, each waiting out
  // a random gap and stall, plus the long hold-off.
  initial begin : watchdog
    #(5_000_000);
    $display("Timed out with %0d results still outstanding.", pending_count);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- priority_time_slice_scheduler_top.f -----
rtl/pts_pkg.sv
rtl/pts_slot_mem.sv
rtl/pts_alu.sv
rtl/priority_time_slice_scheduler_top.sv
sim/pts_sched_checker.sv
sim/priority_time_slice_scheduler_top_test.sv
